FILE: rtl/assert_macros.svh
// assertion helpers used by the counter unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked on the following edge
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/aco_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aco_pkg
// shared codes of the multi-pattern counter: request functions and status
// ---------------------------------------------------------------------------
package aco_pkg;

	typedef enum logic [1:0] {
		F_CLEAR = 2'd0,
		F_PATTERN = 2'd1,
		F_BUILD = 2'd2,
		F_TEXT = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NODE_FULL = 2'd1,
		ST_PAT_LIMIT = 2'd2,
		ST_SEQUENCE = 2'd3
	} status_t;

	localparam int MATCH_W = 10;

endpackage

FILE: rtl/aho_corasick_multi_pattern_counter_unit.sv
`timescale 1ns / 1ps
// clear and reset sweep the root row and the hit map
// pattern byte: goto slot read (S_PRD), check and node insert (S_PCHK), then S_PZERO when a new node row is zeroed
// build: a BFS over the trie visits every (node, byte) slot through the single goto table read port
// text byte: goto read, then a walk of the failure chain that marks hits; a last text byte adds a hit map sweep
// done is a one-cycle strobe, raised as the block returns to idle; busy low accepts the next request
// arst_n starts the root/hit-map sweep with busy high; no result for that sweep
// ---------------------------------------------------------------------------
// aho_corasick_multi_pattern_counter_unit
// trie build, failure-link construction and text scan over ram-held tables
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aho_corasick_multi_pattern_counter_unit #(
	parameter int MAX_NODES = 4096,
	parameter int MAX_PATTERNS = 512,
	parameter int ALPHABET_SIZE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  data_byte,
	input  logic        last,
	output logic        done,
	output logic [1:0]  status,
	output logic [9:0]  match_count,
	output logic        count_valid
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int GD = MAX_NODES * ALPHABET_SIZE;
	localparam int GW = $clog2(GD);
	localparam int AW = $clog2(ALPHABET_SIZE);
	localparam int PW = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
	localparam int PCW = $clog2(MAX_PATTERNS + 1);
	localparam int SWN = (ALPHABET_SIZE > MAX_PATTERNS) ? ALPHABET_SIZE : MAX_PATTERNS;
	localparam int SWW = $clog2(SWN);

	typedef enum logic [4:0] {
		S_INIT, S_IDLE,
		S_PRD, S_PCHK, S_PZERO,
		S_BPOP, S_BP1, S_BP2, S_BC0, S_BC1, S_BC2,
		S_TRD, S_TCUR, S_TWALK, S_TNODE, S_THIT
	} state_t;

	state_t state_q;
	logic phase_q, dropped_q, last_q, full_q, pend_q, done_q, cvalid_q;
	logic [1:0] status_q;
	logic [9:0] mcount_q;
	logic [NW-1:0] cur_q, ncnt_q, p_q, son_q, t_q;
	logic [PCW-1:0] pcnt_q, hcnt_q;
	logic [PW-1:0] pid_q;
	logic [7:0] byte_q;
	logic [GW-1:0] row_q, frow_q;
	logic [AW-1:0] c_q;
	logic [NW:0] head_q, tail_q;
	logic [SWW-1:0] sw_q;

	logic g_we, f_we, n_we, q_we, h_we;
	logic [GW-1:0] g_wa, g_ra;
	logic [NW-1:0] g_wd, g_rd, f_wa, f_ra, f_wd, f_rd, n_wa, n_ra, q_wa, q_ra, q_wd, q_rd;
	logic [PW:0] n_wd, n_rd;
	logic [PW-1:0] h_wa, h_ra;
	logic h_wd, h_rd;

	logic accept, b_ok, slot_free, node_full, c_end, push;
	logic [NW:0] ncnt_inc;
	logic [GW-1:0] slot_addr;

	function automatic logic [GW-1:0] row_of(input logic [NW-1:0] n);
		row_of = GW'(n) * GW'(ALPHABET_SIZE);
	endfunction

	assign accept = start && !busy;
	assign b_ok = 9'(data_byte) < 9'(ALPHABET_SIZE);
	assign slot_addr = row_of(cur_q) + GW'(byte_q);
	assign ncnt_inc = (NW+1)'(ncnt_q) + (NW+1)'(1);
	assign slot_free = (g_rd == '0);
	assign node_full = ncnt_inc >= (NW+1)'(MAX_NODES);
	assign c_end = (c_q == AW'(ALPHABET_SIZE - 1));
	assign push = ((state_q == S_BC1) && (p_q == '0) && !slot_free) ||
		((state_q == S_BC2) && (son_q != '0));

	// memory port steering
	always_comb begin
		g_we = 1'b0; g_wa = slot_addr; g_wd = '0; g_ra = slot_addr;
		f_we = 1'b0; f_wa = '0; f_wd = '0; f_ra = t_q;
		n_we = 1'b0; n_wa = '0; n_wd = '0; n_ra = t_q;
		q_we = 1'b0; q_wa = tail_q[NW-1:0]; q_wd = '0; q_ra = head_q[NW-1:0];
		h_we = 1'b0; h_wa = pid_q; h_wd = 1'b1; h_ra = n_rd[PW-1:0];
		unique case (state_q)
			S_INIT: begin
				g_we = full_q && ((SWW+1)'(sw_q) < (SWW+1)'(ALPHABET_SIZE));
				g_wa = GW'(sw_q);
				h_we = (SWW+1)'(sw_q) < (SWW+1)'(MAX_PATTERNS);
				h_wa = PW'(sw_q);
				h_wd = 1'b0;
				f_we = full_q && (sw_q == '0);
				n_we = full_q && (sw_q == '0);
			end
			S_IDLE: begin
				q_we = accept && (func == aco_pkg::F_BUILD) && !phase_q;
				q_wa = '0;
			end
			S_PCHK: begin
				if (slot_free && !node_full) begin
					g_we = 1'b1;
					g_wd = ncnt_inc[NW-1:0];
					f_we = 1'b1;
					f_wa = ncnt_inc[NW-1:0];
					n_we = 1'b1;
					n_wa = ncnt_inc[NW-1:0];
					n_wd = last_q ? {1'b1, pcnt_q[PW-1:0]} : '0;
				end else if (!slot_free && last_q) begin
					n_we = 1'b1;
					n_wa = g_rd;
					n_wd = {1'b1, pcnt_q[PW-1:0]};
				end
			end
			S_PZERO: begin
				g_we = 1'b1;
				g_wa = row_q + GW'(c_q);
			end
			S_BP1: f_ra = q_rd;
			S_BC0: g_ra = row_q + GW'(c_q);
			S_BC1: begin
				g_ra = frow_q + GW'(c_q);
				f_we = push;
				f_wa = g_rd;
				q_we = push && (tail_q < (NW+1)'(MAX_NODES));
				q_wd = g_rd;
			end
			S_BC2: begin
				f_we = push;
				f_wa = son_q;
				f_wd = g_rd;
				q_we = push && (tail_q < (NW+1)'(MAX_NODES));
				q_wd = son_q;
				g_we = !push;
				g_wa = row_q + GW'(c_q);
				g_wd = g_rd;
			end
			S_THIT: h_we = !h_rd;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			phase_q <= 1'b0;
			dropped_q <= 1'b0;
			full_q <= 1'b1;
			pend_q <= 1'b0;
			done_q <= 1'b0;
			cvalid_q <= 1'b0;
			status_q <= aco_pkg::ST_OK;
			mcount_q <= '0;
			cur_q <= '0;
			ncnt_q <= '0;
			pcnt_q <= '0;
			hcnt_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			sw_q <= '0;
			last_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					sw_q <= sw_q + SWW'(1);
					if (sw_q == SWW'(SWN - 1)) begin
						state_q <= S_IDLE;
						done_q <= pend_q;
					end
				end
				S_IDLE: begin
					if (accept) begin
						status_q <= aco_pkg::ST_OK;
						cvalid_q <= 1'b0;
						mcount_q <= '0;
						byte_q <= data_byte;
						last_q <= last;
						unique case (func)
							aco_pkg::F_CLEAR: begin
								ncnt_q <= '0;
								pcnt_q <= '0;
								hcnt_q <= '0;
								cur_q <= '0;
								phase_q <= 1'b0;
								dropped_q <= 1'b0;
								full_q <= 1'b1;
								pend_q <= 1'b1;
								sw_q <= '0;
								state_q <= S_INIT;
							end
							aco_pkg::F_PATTERN: begin
								if (phase_q) begin
									status_q <= aco_pkg::ST_SEQUENCE;
									done_q <= 1'b1;
								end else if (dropped_q || !b_ok ||
									pcnt_q >= PCW'(MAX_PATTERNS)) begin
									if (!dropped_q) begin
										status_q <= b_ok ? aco_pkg::ST_PAT_LIMIT
											: aco_pkg::ST_SEQUENCE;
									end
									dropped_q <= !last;
									if (last) begin
										cur_q <= '0;
									end
									done_q <= 1'b1;
								end else begin
									state_q <= S_PRD;
								end
							end
							aco_pkg::F_BUILD: begin
								if (phase_q) begin
									status_q <= aco_pkg::ST_SEQUENCE;
									done_q <= 1'b1;
								end else begin
									head_q <= '0;
									tail_q <= (NW+1)'(1);
									state_q <= S_BPOP;
								end
							end
							aco_pkg::F_TEXT: begin
								if (!phase_q) begin
									status_q <= aco_pkg::ST_SEQUENCE;
									done_q <= 1'b1;
								end else if (!b_ok) begin
									// out of alphabet: back to root, finish as a text byte
									cur_q <= '0;
									t_q <= '0;
									state_q <= S_TWALK;
								end else begin
									state_q <= S_TRD;
								end
							end
							default: ;
						endcase
					end
				end
				S_PRD: state_q <= S_PCHK;
				S_PCHK: begin
					if (slot_free && node_full) begin
						status_q <= aco_pkg::ST_NODE_FULL;
						dropped_q <= !last_q;
						if (last_q) begin
							cur_q <= '0;
						end
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (slot_free) begin
						ncnt_q <= ncnt_inc[NW-1:0];
						row_q <= row_of(ncnt_inc[NW-1:0]);
						c_q <= '0;
						cur_q <= last_q ? '0 : ncnt_inc[NW-1:0];
						if (last_q) begin
							pcnt_q <= pcnt_q + PCW'(1);
						end
						state_q <= S_PZERO;
					end else begin
						cur_q <= last_q ? '0 : g_rd;
						if (last_q) begin
							pcnt_q <= pcnt_q + PCW'(1);
						end
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_PZERO: begin
					c_q <= c_q + AW'(1);
					if (c_end) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_BPOP: begin
					if (head_q == tail_q) begin
						cur_q <= '0;
						dropped_q <= 1'b0;
						phase_q <= 1'b1;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						head_q <= head_q + (NW+1)'(1);
						state_q <= S_BP1;
					end
				end
				S_BP1: begin
					p_q <= q_rd;
					state_q <= S_BP2;
				end
				S_BP2: begin
					row_q <= row_of(p_q);
					frow_q <= row_of(f_rd);
					c_q <= '0;
					state_q <= S_BC0;
				end
				S_BC0: state_q <= S_BC1;
				S_BC1, S_BC2: begin
					son_q <= g_rd;
					if (push && (tail_q < (NW+1)'(MAX_NODES))) begin
						tail_q <= tail_q + (NW+1)'(1);
					end
					if ((state_q == S_BC1) && (p_q != '0)) begin
						state_q <= S_BC2;
					end else begin
						c_q <= c_q + AW'(1);
						state_q <= c_end ? S_BPOP : S_BC0;
					end
				end
				S_TRD: state_q <= S_TCUR;
				S_TCUR: begin
					cur_q <= g_rd;
					t_q <= g_rd;
					state_q <= S_TWALK;
				end
				S_TWALK: begin
					if (t_q != '0) begin
						state_q <= S_TNODE;
					end else if (last_q) begin
						// text end: report, then sweep the hit map
						mcount_q <= 10'(hcnt_q);
						cvalid_q <= 1'b1;
						cur_q <= '0;
						hcnt_q <= '0;
						full_q <= 1'b0;
						pend_q <= 1'b1;
						sw_q <= '0;
						state_q <= S_INIT;
					end else begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_TNODE: begin
					t_q <= f_rd;
					pid_q <= n_rd[PW-1:0];
					state_q <= n_rd[PW] ? S_THIT : S_TWALK;
				end
				S_THIT: begin
					if (!h_rd) begin
						hcnt_q <= hcnt_q + PCW'(1);
					end
					state_q <= S_TWALK;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	aco_ram #(.WIDTH(NW), .DEPTH(GD)) u_goto (
		.clk(clk), .we(g_we), .waddr(g_wa), .wdata(g_wd), .raddr(g_ra), .rdata(g_rd)
	);
	aco_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd)
	);
	aco_ram #(.WIDTH(PW + 1), .DEPTH(MAX_NODES)) u_npat (
		.clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd)
	);
	aco_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd)
	);
	aco_ram #(.WIDTH(1), .DEPTH(MAX_PATTERNS)) u_hit (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
	);

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign match_count = mcount_q;
	assign count_valid = cvalid_q;

	`ASSERT_CLK(a_done_idle, done |-> !busy, "result strobe while busy")
	`ASSERT_CLK(a_count_ok, (done && count_valid) |-> (status == aco_pkg::ST_OK),
		"count reported with error status")
	`ASSERT_CLK(a_queue_order, head_q <= tail_q, "bfs queue head passed tail")
	`ASSERT_NEXT(a_hit_bound, state_q == S_THIT, hcnt_q <= PCW'(MAX_PATTERNS),
		"hit count beyond pattern limit")

endmodule

FILE: rtl/aco_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aco_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module aco_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [ADW-1:0]   waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [ADW-1:0]   raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: tb/aho_corasick_multi_pattern_counter_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aho_corasick_multi_pattern_counter_unit_tb
// Self-checking bench for the multi-pattern counter. A directed table covers
// sequence errors, empty and small dictionaries and the byte extremes. Bulk
// runs cover the pattern limit and the node store limit. Random dictionaries
// are then loaded, built and scanned by random texts. Every response is
// checked against a typed expectation or a behavioral automaton kept inside the bench.
// ---------------------------------------------------------------------------
module aho_corasick_multi_pattern_counter_unit_tb;

	localparam int NODES = 4096;
	localparam int PATS = 512;
	localparam int ABC = 256;
	localparam longint CYCLE_LIMIT = 40_000_000;

	typedef struct packed {
		aco_pkg::status_t st;
		logic [9:0] cnt;
		logic vld;
	} resp_t;

	typedef struct {
		aco_pkg::func_t f;
		logic [7:0] b;
		logic l;
		bit typed;
		resp_t r;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	aco_pkg::func_t func;
	logic [7:0] data_byte;
	logic last;
	logic done;
	logic [1:0] status;
	logic [9:0] match_count;
	logic count_valid;

	aho_corasick_multi_pattern_counter_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .data_byte(data_byte), .last(last), .done(done),
		.status(status), .match_count(match_count), .count_valid(count_valid)
	);

	// automaton mirror
	logic [11:0] trans [0:NODES*ABC-1];
	logic [11:0] fail_of [0:NODES-1];
	logic [9:0] id_of [0:NODES-1];
	bit has_id [0:NODES-1];
	logic [11:0] bfs [0:NODES-1];
	bit seen [0:PATS-1];
	int unsigned top_node, n_ids, cur;
	bit searching, dropping;

	resp_t pending_q [$];
	int errs = 0;
	int n_items = 0;
	bit quiet = 0;
	longint cycles = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic void fresh_node(int unsigned n);
		for (int c = 0; c < ABC; c++) trans[n*ABC+c] = '0;
		fail_of[n] = '0;
		id_of[n] = '0;
		has_id[n] = 0;
	endfunction

	function automatic void wipe_dictionary();
		top_node = 0;
		fresh_node(0);
		n_ids = 0;
		for (int i = 0; i < PATS; i++) seen[i] = 0;
		cur = 0;
		searching = 0;
		dropping = 0;
	endfunction

	function automatic void link_failures();
		int unsigned head, tail, p, son;
		head = 0;
		tail = 0;
		bfs[tail++] = 0;
		while (head < tail) begin
			p = bfs[head++];
			for (int c = 0; c < ABC; c++) begin
				son = trans[p*ABC+c];
				if (son != 0) begin
					fail_of[son] = (p == 0) ? 12'd0 : trans[fail_of[p]*ABC+c];
					if (tail < NODES) bfs[tail++] = son;
				end else begin
					trans[p*ABC+c] = (p == 0) ? 12'd0 : trans[fail_of[p]*ABC+c];
				end
			end
		end
		cur = 0;
		dropping = 0;
		searching = 1;
	endfunction

	function automatic resp_t predict_response(aco_pkg::func_t f, logic [7:0] b, logic l);
		resp_t r;
		int unsigned nx, t;
		r = '{st: aco_pkg::ST_OK, cnt: '0, vld: 1'b0};
		case (f)
			aco_pkg::F_CLEAR: wipe_dictionary();
			aco_pkg::F_PATTERN: begin
				if (searching) begin
					r.st = aco_pkg::ST_SEQUENCE;
				end else begin
					if (!dropping) begin
						if (n_ids >= PATS) begin
							r.st = aco_pkg::ST_PAT_LIMIT;
							dropping = 1;
						end else begin
							nx = trans[cur*ABC+b];
							if (nx == 0) begin
								if (top_node + 1 >= NODES) begin
									r.st = aco_pkg::ST_NODE_FULL;
									dropping = 1;
								end else begin
									top_node++;
									fresh_node(top_node);
									trans[cur*ABC+b] = top_node;
									nx = top_node;
								end
							end
							if (!dropping) begin
								cur = nx;
								if (l) begin
									id_of[nx] = n_ids;
									has_id[nx] = 1;
									n_ids++;
								end
							end
						end
					end
					if (l) begin
						cur = 0;
						dropping = 0;
					end
				end
			end
			aco_pkg::F_BUILD: begin
				if (searching) r.st = aco_pkg::ST_SEQUENCE;
				else link_failures();
			end
			default: begin
				if (!searching) begin
					r.st = aco_pkg::ST_SEQUENCE;
				end else begin
					cur = trans[cur*ABC+b];
					t = cur;
					for (int g = 0; t != 0 && g < NODES; g++) begin
						if (has_id[t]) seen[id_of[t]] = 1;
						t = fail_of[t];
					end
					if (l) begin
						for (int i = 0; i < PATS; i++) begin
							if (seen[i] && i < n_ids) r.cnt++;
							seen[i] = 0;
						end
						cur = 0;
						r.vld = 1;
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic issue(aco_pkg::func_t f, logic [7:0] b, logic l, bit typed = 0,
			resp_t typed_r = '0);
		resp_t r;
		if (!quiet && $urandom_range(99) < 19) repeat ($urandom_range(1, 4)) @(negedge clk);
		start = 1;
		func = f;
		data_byte = b;
		last = l;
		do @(posedge clk); while (busy);
		r = predict_response(f, b, l);
		pending_q.push_back(typed ? typed_r : r);
		n_items++;
		@(negedge clk);
		start = 0;
	endtask

	task automatic drain();
		while (pending_q.size() != 0) @(negedge clk);
	endtask

	always @(posedge clk) begin
		resp_t e;
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				errs++;
				if (errs <= 10) $display("unexpected response at cycle %0d", cycles);
			end else begin
				e = pending_q.pop_front();
				if (status !== e.st || match_count !== e.cnt || count_valid !== e.vld) begin
					errs++;
					if (errs <= 10)
						$display("mismatch: exp st=%0d cnt=%0d v=%0d got st=%0d cnt=%0d v=%0d",
							e.st, e.cnt, e.vld, status, match_count, count_valid);
				end
			end
		end
	end

	function automatic logic [7:0] pick_byte();
		// mostly a tiny alphabet so patterns overlap and texts hit them
		if ($urandom_range(99) < 90) return 8'($urandom_range(97, 100));
		return 8'($urandom_range(255));
	endfunction

	localparam resp_t R_OK = '{aco_pkg::ST_OK, 10'd0, 1'b0};
	localparam resp_t R_SEQ = '{aco_pkg::ST_SEQUENCE, 10'd0, 1'b0};

	row_t rows [] = '{
		'{aco_pkg::F_TEXT, 8'h41, 1'b1, 1, R_SEQ},
		'{aco_pkg::F_BUILD, 8'h00, 1'b0, 1, R_OK},
		'{aco_pkg::F_PATTERN, 8'h68, 1'b1, 1, R_SEQ},
		'{aco_pkg::F_BUILD, 8'hff, 1'b1, 1, R_SEQ},
		'{aco_pkg::F_TEXT, 8'h00, 1'b1, 1, '{aco_pkg::ST_OK, 10'd0, 1'b1}},
		'{aco_pkg::F_CLEAR, 8'hff, 1'b1, 1, R_OK},
		'{aco_pkg::F_PATTERN, "h", 1'b0, 0, R_OK},
		'{aco_pkg::F_PATTERN, "e", 1'b1, 0, R_OK},
		'{aco_pkg::F_PATTERN, "s", 1'b0, 0, R_OK},
		'{aco_pkg::F_PATTERN, "h", 1'b0, 0, R_OK},
		'{aco_pkg::F_PATTERN, "e", 1'b1, 0, R_OK},
		'{aco_pkg::F_PATTERN, "h", 1'b0, 0, R_OK},
		'{aco_pkg::F_PATTERN, "e", 1'b0, 0, R_OK},
		'{aco_pkg::F_PATTERN, "r", 1'b0, 0, R_OK},
		'{aco_pkg::F_PATTERN, "s", 1'b1, 0, R_OK},
		'{aco_pkg::F_PATTERN, 8'h00, 1'b0, 0, R_OK},
		'{aco_pkg::F_PATTERN, 8'hff, 1'b1, 0, R_OK},
		'{aco_pkg::F_PATTERN, "h", 1'b1, 0, R_OK},
		'{aco_pkg::F_PATTERN, "x", 1'b0, 0, R_OK},
		'{aco_pkg::F_BUILD, 8'h00, 1'b0, 0, R_OK},
		'{aco_pkg::F_TEXT, "u", 1'b0, 0, R_OK},
		'{aco_pkg::F_TEXT, "s", 1'b0, 0, R_OK},
		'{aco_pkg::F_TEXT, "h", 1'b0, 0, R_OK},
		'{aco_pkg::F_TEXT, "e", 1'b0, 0, R_OK},
		'{aco_pkg::F_TEXT, "r", 1'b0, 0, R_OK},
		'{aco_pkg::F_TEXT, "s", 1'b1, 0, R_OK},
		'{aco_pkg::F_TEXT, 8'h00, 1'b0, 0, R_OK},
		'{aco_pkg::F_TEXT, 8'hff, 1'b1, 0, R_OK}
	};

	initial begin
		int npat, ntxt, len, wait_cnt;
		arst_n = 0;
		start = 0;
		func = aco_pkg::F_CLEAR;
		data_byte = '0;
		last = 0;
		wipe_dictionary();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (rows[i]) issue(rows[i].f, rows[i].b, rows[i].l, rows[i].typed, rows[i].r);

		// pattern table full: one more id is refused
		quiet = 1;
		issue(aco_pkg::F_CLEAR, 8'h00, 1'b0);
		for (int i = 0; i < PATS; i++) issue(aco_pkg::F_PATTERN, 8'h61, 1'b1);
		issue(aco_pkg::F_PATTERN, 8'h61, 1'b1, 1, '{aco_pkg::ST_PAT_LIMIT, 10'd0, 1'b0});
		issue(aco_pkg::F_BUILD, 8'h00, 1'b0);
		issue(aco_pkg::F_TEXT, 8'h61, 1'b1, 1, '{aco_pkg::ST_OK, 10'd1, 1'b1});

		// node store full: one long pattern that outgrows it
		issue(aco_pkg::F_CLEAR, 8'h00, 1'b0);
		for (int i = 0; i < NODES - 1; i++) issue(aco_pkg::F_PATTERN, 8'h62, 1'b0);
		issue(aco_pkg::F_PATTERN, 8'h62, 1'b0, 1, '{aco_pkg::ST_NODE_FULL, 10'd0, 1'b0});
		issue(aco_pkg::F_PATTERN, 8'h62, 1'b0, 1, R_OK);
		issue(aco_pkg::F_PATTERN, 8'h62, 1'b1, 1, R_OK);
		issue(aco_pkg::F_PATTERN, 8'h63, 1'b1);
		quiet = 0;

		// sender holds off until the block has answered everything
		drain();
		while (n_items < NODES + PATS + 2100) begin
			quiet = (n_items > NODES + PATS + 900 && n_items < NODES + PATS + 1200);
			issue(aco_pkg::F_CLEAR, pick_byte(), 1'($urandom_range(1)));
			npat = $urandom_range(1, 8);
			for (int p = 0; p < npat; p++) begin
				len = $urandom_range(1, 5);
				for (int k = 0; k < len; k++)
					issue(aco_pkg::F_PATTERN, pick_byte(), k == len - 1);
				if ($urandom_range(99) < 5)
					issue(aco_pkg::F_TEXT, pick_byte(), 1'($urandom_range(1)));
			end
			// sometimes leave a pattern unfinished before the build
			if ($urandom_range(99) < 10) issue(aco_pkg::F_PATTERN, pick_byte(), 1'b0);
			issue(aco_pkg::F_BUILD, pick_byte(), 1'($urandom_range(1)));
			ntxt = $urandom_range(1, 8);
			for (int t = 0; t < ntxt; t++) begin
				len = $urandom_range(1, 12);
				for (int k = 0; k < len; k++) issue(aco_pkg::F_TEXT, pick_byte(), k == len - 1);
				if ($urandom_range(99) < 5)
					issue($urandom_range(1) ? aco_pkg::F_PATTERN : aco_pkg::F_BUILD,
						pick_byte(), 1'($urandom_range(1)));
			end
			// a text left open runs into the next clear
			if ($urandom_range(99) < 20) issue(aco_pkg::F_TEXT, pick_byte(), 1'b0);
		end

		wait_cnt = 0;
		while (pending_q.size() != 0 && wait_cnt < 2_000_000) begin
			@(negedge clk);
			wait_cnt++;
		end
		repeat (600) @(negedge clk);
		if (errs == 0 && pending_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl
rtl/aco_pkg.sv
rtl/aco_ram.sv
rtl/aho_corasick_multi_pattern_counter_unit.sv
tb/aho_corasick_multi_pattern_counter_unit_tb.sv
